@@ hdl/admittance_velocity_integrator_assert.svh @@
// assertion macros for the velocity integrator
`ifndef ADMITTANCE_VELOCITY_INTEGRATOR_ASSERT_SVH
`define ADMITTANCE_VELOCITY_INTEGRATOR_ASSERT_SVH

`define AVI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define AVI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/avi_pkg.sv @@
package avi_pkg;

	localparam int FracBitsDefault = 16;
	localparam int NumAxes = 6;
	localparam int HoldGain = 3;

	localparam logic [47:0] InvMassReset = 48'd1099528405248;
	localparam logic [31:0] MaxAccelReset = 32'd65536;
	localparam logic [23:0] LoopPeriodReset = 24'd16777;

	typedef enum logic [2:0] {
		REG_INV_MASS_LIN = 3'd0,
		REG_INV_MASS_ANG = 3'd1,
		REG_DAMP_LIN = 3'd2,
		REG_DAMP_ANG = 3'd3,
		REG_MAX_ACCEL = 3'd4,
		REG_LOOP_PERIOD = 3'd5,
		REG_AXIS_ENABLE = 3'd6,
		REG_START_ENABLE = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DAMP,
		ST_NET,
		ST_ACC,
		ST_SQ,
		ST_SQRT,
		ST_CMP,
		ST_DIV,
		ST_INTEG,
		ST_VEL,
		ST_HOLD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic axis_clr;
		logic axis_inc;
		logic do_damp;
		logic do_net;
		logic do_acc;
		logic do_sq;
		logic sqrt_start;
		logic div_start;
		logic div_write;
		logic do_integ;
		logic do_vel;
		logic do_hold;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic axis_last;
		logic lin_last;
		logic sqrt_done;
		logic div_done;
		logic over;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (x < -66'sh0_8000_0000) return 32'sh8000_0000;
		return x[31:0];
	endfunction

endpackage

@@ hdl/avi_if.sv @@
interface avi_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] force_x, force_y, force_z;
	logic signed [31:0] torque_x, torque_y, torque_z;
	logic signed [31:0] height;
	modport source(output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
		height, input ready);
	modport sink(input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
		height, output ready);
endinterface

interface avi_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] vel_x, vel_y, vel_z;
	logic signed [31:0] rate_x, rate_y, rate_z;
	logic publish;
	modport source(output valid, vel_x, vel_y, vel_z, rate_x, rate_y, rate_z, publish,
		input ready);
	modport sink(input valid, vel_x, vel_y, vel_z, rate_x, rate_y, rate_z, publish,
		output ready);
endinterface

interface avi_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [63:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/admittance_velocity_integrator.sv @@
// sequencing: the six-axis sequential loop, the square root and, when the acceleration
// limit engages, three compare and divide passes lie between input request and result
// one request at a time; a new request is taken only after the result is accepted, so output stalls hold it off
// reset: arst_n asynchronous active low clears velocities, registers to defaults
module admittance_velocity_integrator #(
	parameter int FRAC_BITS = avi_pkg::FracBitsDefault
) (
	input logic clk,
	input logic arst_n,
	avi_in_if.sink in_ch,
	avi_out_if.source out_ch,
	avi_cfg_if.sink cfg
);

	`include "admittance_velocity_integrator_assert.svh"

	logic [47:0] iml_q, ima_q, dl_q, da_q;
	logic [31:0] ma_q;
	logic [23:0] lp_q;
	logic [2:0] ae_q;
	logic se_q;
	logic busy, out_valid;
	avi_pkg::cmd_t cmd;
	avi_pkg::sts_t sts;
	logic signed [31:0] wrench [6];
	logic signed [31:0] vel [6];
	logic in_fire, out_fire;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = !busy;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iml_q <= avi_pkg::InvMassReset;
			ima_q <= avi_pkg::InvMassReset;
			dl_q <= '0;
			da_q <= '0;
			ma_q <= avi_pkg::MaxAccelReset;
			lp_q <= avi_pkg::LoopPeriodReset;
			ae_q <= 3'b111;
			se_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (avi_pkg::reg_idx_t'(cfg.index))
				avi_pkg::REG_INV_MASS_LIN: iml_q <= cfg.data[47:0];
				avi_pkg::REG_INV_MASS_ANG: ima_q <= cfg.data[47:0];
				avi_pkg::REG_DAMP_LIN: dl_q <= cfg.data[47:0];
				avi_pkg::REG_DAMP_ANG: da_q <= cfg.data[47:0];
				avi_pkg::REG_MAX_ACCEL: ma_q <= cfg.data[31:0];
				avi_pkg::REG_LOOP_PERIOD: lp_q <= cfg.data[23:0];
				avi_pkg::REG_AXIS_ENABLE: ae_q <= cfg.data[2:0];
				avi_pkg::REG_START_ENABLE: se_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign wrench[0] = in_ch.force_x;
	assign wrench[1] = in_ch.force_y;
	assign wrench[2] = in_ch.force_z;
	assign wrench[3] = in_ch.torque_x;
	assign wrench[4] = in_ch.torque_y;
	assign wrench[5] = in_ch.torque_z;

	avi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .busy(busy), .out_valid(out_valid), .cmd(cmd)
	);

	avi_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.wrench(wrench), .height(in_ch.height),
		.inv_mass_lin(iml_q), .inv_mass_ang(ima_q), .damp_lin(dl_q), .damp_ang(da_q),
		.max_accel(ma_q), .loop_period(lp_q), .vel(vel)
	);

	assign out_ch.valid = out_valid;
	assign out_ch.vel_x = ae_q[0] ? vel[0] : '0;
	assign out_ch.vel_y = ae_q[1] ? vel[1] : '0;
	assign out_ch.vel_z = ae_q[2] ? vel[2] : '0;
	assign out_ch.rate_x = vel[3];
	assign out_ch.rate_y = vel[4];
	assign out_ch.rate_z = vel[5];
	assign out_ch.publish = se_q;

	`AVI_ASSERT_IMPL(a_no_in_when_out, clk, arst_n, out_valid, !in_ch.ready,
		"input ready while result pending")
	`AVI_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_fire, busy, "not busy after accept")
	`AVI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ch.ready, out_valid,
		"result dropped")

endmodule

@@ hdl/avi_ctrl.sv @@
module avi_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic out_fire,
	input avi_pkg::sts_t sts,
	output logic busy,
	output logic out_valid,
	output avi_pkg::cmd_t cmd
);

	avi_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= avi_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			avi_pkg::ST_IDLE: if (in_fire) state_d = avi_pkg::ST_DAMP;
			avi_pkg::ST_DAMP: state_d = avi_pkg::ST_NET;
			avi_pkg::ST_NET: state_d = avi_pkg::ST_ACC;
			avi_pkg::ST_ACC: state_d = sts.axis_last ? avi_pkg::ST_SQ : avi_pkg::ST_DAMP;
			avi_pkg::ST_SQ: if (sts.lin_last) state_d = avi_pkg::ST_SQRT;
			avi_pkg::ST_SQRT: if (sts.sqrt_done) state_d = avi_pkg::ST_CMP;
			avi_pkg::ST_CMP: state_d = sts.over ? avi_pkg::ST_DIV : avi_pkg::ST_INTEG;
			avi_pkg::ST_DIV: if (sts.div_done)
				state_d = sts.lin_last ? avi_pkg::ST_INTEG : avi_pkg::ST_CMP;
			avi_pkg::ST_INTEG: state_d = avi_pkg::ST_VEL;
			avi_pkg::ST_VEL: if (sts.axis_last) state_d = avi_pkg::ST_HOLD;
				else state_d = avi_pkg::ST_INTEG;
			avi_pkg::ST_HOLD: state_d = avi_pkg::ST_OUT;
			avi_pkg::ST_OUT: if (out_fire) state_d = avi_pkg::ST_IDLE;
			default: state_d = avi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			avi_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.load = in_fire;
				cmd.axis_clr = 1'b1;
			end
			avi_pkg::ST_DAMP: cmd.do_damp = 1'b1;
			avi_pkg::ST_NET: cmd.do_net = 1'b1;
			avi_pkg::ST_ACC: begin
				cmd.do_acc = 1'b1;
				cmd.axis_inc = !sts.axis_last;
				cmd.axis_clr = sts.axis_last;
			end
			avi_pkg::ST_SQ: begin
				cmd.do_sq = 1'b1;
				cmd.axis_inc = !sts.lin_last;
				cmd.axis_clr = sts.lin_last;
				cmd.sqrt_start = sts.lin_last;
			end
			avi_pkg::ST_SQRT: ;
			avi_pkg::ST_CMP: begin
				cmd.div_start = sts.over;
				cmd.axis_clr = !sts.over;
			end
			avi_pkg::ST_DIV: if (sts.div_done) begin
				cmd.div_write = 1'b1;
				cmd.axis_inc = !sts.lin_last;
				cmd.axis_clr = sts.lin_last;
			end
			avi_pkg::ST_INTEG: cmd.do_integ = 1'b1;
			avi_pkg::ST_VEL: begin
				cmd.do_vel = 1'b1;
				cmd.axis_inc = !sts.axis_last;
			end
			avi_pkg::ST_HOLD: cmd.do_hold = 1'b1;
			avi_pkg::ST_OUT: begin
				out_valid = 1'b1;
				cmd.out_load = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/avi_datapath.sv @@
module avi_datapath #(
	parameter int FRAC_BITS = avi_pkg::FracBitsDefault
) (
	input logic clk,
	input logic arst_n,
	input avi_pkg::cmd_t cmd,
	output avi_pkg::sts_t sts,
	input logic signed [31:0] wrench [6],
	input logic signed [31:0] height,
	input logic [47:0] inv_mass_lin,
	input logic [47:0] inv_mass_ang,
	input logic [47:0] damp_lin,
	input logic [47:0] damp_ang,
	input logic [31:0] max_accel,
	input logic [23:0] loop_period,
	output logic signed [31:0] vel [6]
);

	logic [2:0] axis_q;
	logic signed [31:0] w_q [6];
	logic signed [31:0] h_q;
	logic signed [31:0] acc_q [6];
	logic signed [31:0] vel_q [6];
	logic signed [56:0] prod_q;
	logic signed [31:0] net_q;
	logic [65:0] sum_q;
	logic [32:0] norm_q;

	logic [1:0] lane;
	logic [15:0] im, dg;
	logic signed [31:0] a_cur;
	logic [31:0] mag;

	// square root of the linear acceleration norm
	logic [65:0] rem_q;
	logic [32:0] root_q;
	logic [5:0] scnt_q;
	logic sbusy_q;
	// shared restoring divider
	logic [63:0] dnum_q;
	logic [64:0] drem_q;
	logic [63:0] dquo_q;
	logic [6:0] dcnt_q;
	logic dbusy_q, ddone_q;

	assign lane = (axis_q >= 3'd3) ? 2'(axis_q - 3'd3) : axis_q[1:0];
	assign im = (axis_q >= 3'd3) ? inv_mass_ang[16*lane +: 16] : inv_mass_lin[16*lane +: 16];
	assign dg = (axis_q >= 3'd3) ? damp_ang[16*lane +: 16] : damp_lin[16*lane +: 16];
	assign a_cur = acc_q[axis_q];
	assign mag = a_cur[31] ? 32'(-a_cur) : 32'(a_cur);

	assign sts.axis_last = (axis_q == 3'd5);
	assign sts.lin_last = (axis_q == 3'd2);
	assign sts.sqrt_done = !sbusy_q;
	assign sts.div_done = ddone_q;
	assign sts.over = ({1'b0, norm_q} > {2'b0, max_accel});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= '0;
			sbusy_q <= 1'b0;
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			for (int i = 0; i < 6; i++) vel_q[i] <= '0;
		end else begin
			if (cmd.axis_clr) axis_q <= '0;
			else if (cmd.axis_inc) axis_q <= axis_q + 3'd1;
			if (cmd.load) begin
				for (int i = 0; i < 6; i++) w_q[i] <= wrench[i];
				h_q <= height;
				sum_q <= '0;
			end
			if (cmd.do_damp) prod_q <= 57'($signed({1'b0, dg}) * vel_q[axis_q]);
			if (cmd.do_net)
				net_q <= avi_pkg::sat32(66'(w_q[axis_q]) - 66'(prod_q >>> 8));
			if (cmd.do_acc)
				acc_q[axis_q] <= avi_pkg::sat32(66'(($signed({1'b0, im}) * net_q) >>> 8));
			if (cmd.do_sq) sum_q <= sum_q + 66'(64'(mag) * 64'(mag));
			if (cmd.sqrt_start) begin
				rem_q <= sum_q + 66'(64'(mag) * 64'(mag));
				root_q <= '0;
				scnt_q <= 6'd32;
				sbusy_q <= 1'b1;
			end else if (sbusy_q) begin
				if (rem_q[65:0] >= ((66'(root_q) << (scnt_q + 1)) | (66'd1 << (2*scnt_q))))
				begin
					rem_q <= rem_q - ((66'(root_q) << (scnt_q + 1)) | (66'd1 << (2*scnt_q)));
					root_q <= root_q | (33'd1 << scnt_q);
				end
				if (scnt_q == 6'd0) sbusy_q <= 1'b0;
				else scnt_q <= scnt_q - 6'd1;
			end
			if (sbusy_q && scnt_q == 6'd0) norm_q <= (rem_q >= ((66'(root_q) << 1) | 66'd1))
				? (root_q | 33'd1) : root_q;
			ddone_q <= 1'b0;
			if (cmd.div_start) begin
				dnum_q <= 64'(mag) * 64'(max_accel);
				drem_q <= '0;
				dcnt_q <= 7'd64;
				dbusy_q <= 1'b1;
			end else if (dbusy_q) begin
				if ({drem_q[63:0], dnum_q[63]} >= 65'(norm_q)) begin
					drem_q <= {drem_q[63:0], dnum_q[63]} - 65'(norm_q);
					dquo_q <= {dquo_q[62:0], 1'b1};
				end else begin
					drem_q <= {drem_q[63:0], dnum_q[63]};
					dquo_q <= {dquo_q[62:0], 1'b0};
				end
				dnum_q <= dnum_q << 1;
				dcnt_q <= dcnt_q - 7'd1;
				if (dcnt_q == 7'd1) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
			if (cmd.div_write)
				acc_q[axis_q] <= a_cur[31] ? -$signed(dquo_q[31:0]) : $signed(dquo_q[31:0]);
			if (cmd.do_integ)
				prod_q <= 57'(acc_q[axis_q] * $signed({1'b0, loop_period}));
			if (cmd.do_vel)
				vel_q[axis_q] <= avi_pkg::sat32(66'(vel_q[axis_q]) + 66'(prod_q >>> 24));
			if (cmd.do_hold)
				vel_q[2] <= avi_pkg::sat32(-66'(avi_pkg::HoldGain) *
					(66'(h_q) - (66'sd1 <<< (FRAC_BITS - 1))));
		end
	end

	assign vel = vel_q;

endmodule
